[src/assert_macros.svh]
// Assertion helpers shared by the checker modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[src/mxh64_pkg.sv]
`default_nettype none

package mxh64_pkg;

    localparam logic [63:0] SEED_CONST  = 64'h9e3779b97f4a7c15;
    localparam int          CHUNK_BYTES = 65536;
    localparam int          CHUNK_POS_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int HASH_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ABSORB        = 2'd0,
        CMD_ABSORB_FINISH = 2'd1,
        CMD_FINISH        = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

[src/multiply_xor_stream_hash64_top.sv]
// From an input transfer to the hash on m_axis, the item passes the input register, then the result register.
// Throughput: one input transfer per cycle except while a finish is stalled; the running-hash update is combinational.
// A finish stalls the input only while the result register holds an untaken hash.
// Reset (rst_n low, asynchronous) empties both registers, loads the seed and clears the count.
`default_nettype none

module multiply_xor_stream_hash64_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [mxh64_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  wire logic [mxh64_pkg::CMD_W-1:0]     s_axis_tuser,  // [1:0] cmd
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [mxh64_pkg::HASH_W-1:0]         m_axis_tdata   // [63:0] hash_value
);
    import mxh64_pkg::*;

    localparam logic [CHUNK_POS_W-1:0] CHUNK_LAST = CHUNK_POS_W'(CHUNK_BYTES - 1);
    localparam logic [31:0]            SEED_LO    = SEED_CONST[31:0];
    localparam logic [31:0]            SEED_HI    = SEED_CONST[63:32];

    logic                   in_valid_reg, in_valid_next;
    logic [CMD_W-1:0]       in_cmd_reg;
    logic [BYTE_W-1:0]      in_byte_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [HASH_W-1:0]      out_hash_reg, out_hash_next;

    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic [HASH_W-1:0]      count_reg, count_next;
    logic [HASH_W-1:0]      done_reg, done_next;
    logic [CHUNK_POS_W-1:0] chunk_pos_reg, chunk_pos_next;

    logic                   do_absorb;
    logic                   do_finish;
    logic                   advance;
    logic                   take_in;

    logic [HASH_W-1:0]      mix_in;
    logic [HASH_W-1:0]      prod_ll;
    logic [31:0]            prod_lh;
    logic [31:0]            prod_hl;
    logic [HASH_W-1:0]      prod;
    logic [HASH_W-1:0]      shuffled;
    logic [HASH_W-1:0]      hash_abs;
    logic [HASH_W-1:0]      count_abs;
    logic [HASH_W-1:0]      done_abs;
    logic [CHUNK_POS_W-1:0] chunk_pos_abs;

    always_comb
    begin
        do_absorb = 1'b0;
        do_finish = 1'b0;
        case (in_cmd_reg)
            CMD_ABSORB:
            begin
                do_absorb = 1'b1;
            end
            CMD_ABSORB_FINISH:
            begin
                do_absorb = 1'b1;
                do_finish = 1'b1;
            end
            CMD_FINISH:
            begin
                do_finish = 1'b1;
            end
            default:
            begin
                do_absorb = 1'b0;
                do_finish = 1'b0;
            end
        endcase
    end

    // A held item moves on unless it carries a hash and the result register is blocked.
    assign advance       = in_valid_reg && !(do_finish && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // The low 64 bits of the product are built from three 32-bit partial products.
    assign mix_in   = hash_reg ^ {{(HASH_W - BYTE_W){in_byte_reg[BYTE_W-1]}}, in_byte_reg};
    assign prod_ll  = {32'd0, mix_in[31:0]} * {32'd0, SEED_LO};
    assign prod_lh  = mix_in[31:0] * SEED_HI;
    assign prod_hl  = mix_in[63:32] * SEED_LO;
    assign prod     = prod_ll + {prod_lh + prod_hl, 32'd0};
    assign shuffled = prod ^ {prod[HASH_W-6:0], 5'd0};

    // done_reg tracks the bytes of all completed chunks without any division.
    assign hash_abs      = do_absorb ? shuffled + done_reg : hash_reg;
    assign count_abs     = do_absorb ? count_reg + 64'd1 : count_reg;
    assign done_abs      = (do_absorb && chunk_pos_reg == CHUNK_LAST)
                           ? done_reg + 64'(CHUNK_BYTES) : done_reg;
    assign chunk_pos_abs = !do_absorb ? chunk_pos_reg
                           : (chunk_pos_reg == CHUNK_LAST) ? '0
                           : chunk_pos_reg + CHUNK_POS_W'(1);

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        hash_next      = hash_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        chunk_pos_next = chunk_pos_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            in_valid_next = 1'b0;
            if (do_finish)
            begin
                out_valid_next = 1'b1;
                out_hash_next  = hash_abs ^ count_abs ^ {count_abs[31:0], 32'd0};
                hash_next      = SEED_CONST;
                count_next     = '0;
                done_next      = '0;
                chunk_pos_next = '0;
            end
            else
            begin
                hash_next      = hash_abs;
                count_next     = count_abs;
                done_next      = done_abs;
                chunk_pos_next = chunk_pos_abs;
            end
        end
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_reg      <= SEED_CONST;
            count_reg     <= '0;
            done_reg      <= '0;
            chunk_pos_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            chunk_pos_reg <= chunk_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        out_hash_reg <= out_hash_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_hash_reg;

endmodule

`default_nettype wire

[src/mxh64_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module mxh64_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    input  wire logic [mxh64_pkg::BYTE_W-1:0] s_axis_tdata,
    input  wire logic [mxh64_pkg::CMD_W-1:0]  s_axis_tuser,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    input  wire logic [mxh64_pkg::HASH_W-1:0] m_axis_tdata
);
    import mxh64_pkg::*;

    logic finish_in;

    assign finish_in = s_axis_tvalid && s_axis_tready && s_axis_tdata == s_axis_tdata
                       && (s_axis_tuser == CMD_ABSORB_FINISH || s_axis_tuser == CMD_FINISH);

    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
        "result withdrawn before its transfer")
    `ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
        "stalled hash changed")
    `ASSERT_SAME(a_ready_only_blocked, !s_axis_tready, m_axis_tvalid && !m_axis_tready,
        "input stalled while the result side is free")
    `ASSERT_SAME(a_result_from_finish, $rose(m_axis_tvalid), $past(finish_in, 2),
        "hash emitted without a finish two cycles earlier")

endmodule

bind multiply_xor_stream_hash64_top mxh64_checker u_mxh64_checker (.*);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import mxh64_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         RAND_ITEMS  = 800;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic        typed;
        logic [63:0] hash;
    } dir_row_t;

    localparam int DIR_ROWS = 17;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{CMD_FINISH,        8'h5a, 1'b1, SEED_CONST},
        '{CMD_FINISH,        8'hff, 1'b1, SEED_CONST},
        '{CMD_UNUSED,        8'h80, 1'b0, 64'h0},
        '{CMD_FINISH,        8'h00, 1'b1, SEED_CONST},
        '{CMD_ABSORB,        8'h00, 1'b0, 64'h0},
        '{CMD_ABSORB,        8'hff, 1'b0, 64'h0},
        '{CMD_ABSORB,        8'h80, 1'b0, 64'h0},
        '{CMD_UNUSED,        8'h7f, 1'b0, 64'h0},
        '{CMD_ABSORB,        8'h7f, 1'b0, 64'h0},
        '{CMD_ABSORB_FINISH, 8'h01, 1'b0, 64'h0},
        '{CMD_ABSORB_FINISH, 8'h00, 1'b0, 64'h0},
        '{CMD_ABSORB_FINISH, 8'hff, 1'b0, 64'h0},
        '{CMD_ABSORB_FINISH, 8'h80, 1'b0, 64'h0},
        '{CMD_ABSORB,        8'haa, 1'b0, 64'h0},
        '{CMD_ABSORB,        8'h55, 1'b0, 64'h0},
        '{CMD_FINISH,        8'hff, 1'b0, 64'h0},
        '{CMD_FINISH,        8'h33, 1'b1, SEED_CONST}
    };

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;
    logic [CMD_W-1:0]  s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [HASH_W-1:0] m_axis_tdata;

    logic [63:0] model_hash;
    logic [63:0] model_count;
    logic [63:0] hash_expected [$];
    int          err_cnt;
    int          cycle_cnt;
    int          burst_left;
    bit          sender_gaps;

    multiply_xor_stream_hash64_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic hash_model_step(input logic [1:0] c, input logic [7:0] b,
                                   output bit emits, output logic [63:0] h);
        logic [63:0] ext;
        logic [63:0] done;
        logic [63:0] chunk;
        emits = 1'b0;
        h     = 64'h0;
        chunk = 64'(CHUNK_BYTES);
        if (c == CMD_ABSORB || c == CMD_ABSORB_FINISH)
        begin
            ext         = {{56{b[7]}}, b};
            done        = (model_count / chunk) * chunk;
            model_hash  = model_hash ^ ext;
            model_hash  = model_hash * SEED_CONST;
            model_hash  = model_hash ^ (model_hash << 5);
            model_hash  = model_hash + done;
            model_count = model_count + 64'd1;
        end
        if (c == CMD_ABSORB_FINISH || c == CMD_FINISH)
        begin
            h           = model_hash ^ model_count ^ (model_count << 32);
            emits       = 1'b1;
            model_hash  = SEED_CONST;
            model_count = 64'h0;
        end
    endtask

    task automatic send_item(input logic [1:0] c, input logic [7:0] b,
                             input logic typed, input logic [63:0] typed_hash);
        int          gap;
        bit          emits;
        logic [63:0] h;
        if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        hash_model_step(c, b, emits, h);
        if (emits)
            hash_expected.push_back(typed ? typed_hash : h);
    endtask

    task automatic send_stream(input int len);
        int k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_UNUSED, 8'($urandom), 1'b0, 64'h0);
            if (k == len - 1 && $urandom_range(0, 1) == 1)
                send_item(CMD_ABSORB_FINISH, 8'($urandom), 1'b0, 64'h0);
            else
                send_item(CMD_ABSORB, 8'($urandom), 1'b0, 64'h0);
        end
        if (len == 0 || $urandom_range(0, 1) == 0)
            send_item(CMD_FINISH, 8'($urandom), 1'b0, 64'h0);
    endtask

    // The receiver picks a new random stall behavior whenever its phase counter runs out.
    initial
    begin : receiver
        int mode;
        int phase;
        m_axis_tready = 1'b0;
        mode          = 0;
        phase         = 0;
        forever
        begin
            @(negedge clk);
            if (phase == 0)
            begin
                mode  = $urandom_range(0, 3);
                phase = $urandom_range(20, 80);
            end
            phase--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (phase % 16 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : hash_monitor
        logic [63:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (hash_expected.size() == 0)
                report_mismatch("unexpected hash", m_axis_tdata, 64'h0);
            else
            begin
                want = hash_expected.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch("hash_value", m_axis_tdata, want);
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int sent;
        int len;
        bit paused;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rst_n         = 1'b0;
        err_cnt       = 0;
        burst_left    = 0;
        sender_gaps   = 1'b1;
        model_hash    = SEED_CONST;
        model_count   = 64'h0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].typed,
                      dir_rows[i].hash);

        sent   = 0;
        paused = 1'b0;
        while (sent < RAND_ITEMS)
        begin
            sender_gaps = ($urandom_range(0, 4) != 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150)
                                               : $urandom_range(0, 24);
            send_stream(len);
            sent += len + 1;
            if (!paused && sent > RAND_ITEMS / 2)
            begin
                paused = 1'b1;
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                burst_left = 0;
                while (hash_expected.size() != 0)
                    @(posedge clk);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (hash_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (hash_expected.size() != 0)
            report_mismatch("hashes left over", 64'(hash_expected.size()), 64'h0);
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
